>>> hw/rtl/bbr_pkg.sv
// Shared types, constants and helpers for the 3x3 RGBA box blur.
// No dependencies; used by every module of the block.
package bbr_pkg;

   localparam int MaxWidth  = 2048;                 // deepest supported line
   localparam int ColBits   = $clog2(MaxWidth);     // line buffer address
   localparam int CfgBits   = 12;                   // register data width
   localparam int RowBits   = 12;                   // row counters
   localparam int CmpBits   = CfgBits + 2;          // room for count+1 compares
   localparam int ChanBits  = 8;
   localparam int PixBits   = 4 * ChanBits;
   localparam int SumBits   = ChanBits + 4;         // nine channel values
   localparam int CntBits   = 4;                    // neighbour count 1..9
   localparam int RecipBits = 17;
   localparam int RecipShift = 16;
   localparam int ProdBits  = SumBits + RecipBits;
   localparam int IdxBits   = 4;                    // register index

   localparam logic [CfgBits-1:0] WidthReset  = CfgBits'(640);
   localparam logic [CfgBits-1:0] HeightReset = CfgBits'(480);
   localparam logic [RowBits-1:0] RowMax      = {RowBits{1'b1}};

   typedef enum logic [IdxBits-1:0] {
      CSR_IMAGE_WIDTH  = 4'd0,
      CSR_IMAGE_HEIGHT = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [ChanBits-1:0] red_in;
      logic [ChanBits-1:0] green_in;
      logic [ChanBits-1:0] blue_in;
      logic [ChanBits-1:0] alpha_in;
      logic                drain;
   } pixel_in_type;

   typedef struct packed {
      logic [ChanBits-1:0] red_out;
      logic [ChanBits-1:0] green_out;
      logic [ChanBits-1:0] blue_out;
      logic [ChanBits-1:0] alpha_out;
      logic                frame_last;
   } pixel_out_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // take input beat, read line buffers
      logic shift;    // write line buffers, shift window
      logic sum;      // masked neighbourhood sums
      logic mul;      // reciprocal multiply
      logic emit;     // load result register, step output position
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fire;     // current beat produces a result
      logic out_free; // result register can take a beat
   } dp_status_type;

   // ceil(2^16 / n); exact floor division for sums up to 9*255
   function automatic logic [RecipBits-1:0] recip(input logic [CntBits-1:0] n);
      logic [RecipBits-1:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/bbr_ctrl.sv
// Sequencer for the box blur: steps one beat through read and shift and,
// if it yields a result, sum, multiply and result load. Depends on bbr_pkg.
module bbr_ctrl import bbr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SHIFT = 5'b00010,
      ST_SUM   = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = status.fire ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/bbr_dpath.sv
// Box blur datapath: line buffers, 3x3 window, position counters, sums,
// reciprocal divide and result register. Depends on bbr_pkg.
module bbr_dpath import bbr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [CfgBits-1:0]  live_width,
   input  logic [CfgBits-1:0]  live_height,
   input  pixel_in_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pixel_out_type       rsp_data
);

   logic [PixBits-1:0] upper_mem  [MaxWidth];
   logic [PixBits-1:0] middle_mem [MaxWidth];

   logic [PixBits-1:0] top_rd_ff, mid_rd_ff, px_ff;
   logic [ColBits-1:0] addr_ff;
   logic [PixBits-1:0] win_ff [9];

   logic [ColBits-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RowBits-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic               armed_ff, armed_in, fire_ff, fire_in;

   logic [SumBits-1:0]  sum_ff [4];
   logic [SumBits-1:0]  sum_in [4];
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [ProdBits-1:0] prod_ff [4];

   logic               rsp_valid_ff;
   pixel_out_type      rsp_data_ff, rsp_data_in;

   logic [CmpBits-1:0] in_col_next, out_col_next, out_row_next;
   logic               in_col_end, col_end, row_end, last;
   logic [2:0]         row_ok, col_ok;
   logic [8:0]         use_mask;

   // ---- position tracking ----
   assign in_col_next  = CmpBits'(in_col_ff) + CmpBits'(1);
   assign out_col_next = CmpBits'(out_col_ff) + CmpBits'(1);
   assign out_row_next = CmpBits'(out_row_ff) + CmpBits'(1);
   assign in_col_end   = in_col_next >= CmpBits'(live_width);
   assign col_end      = out_col_next >= CmpBits'(live_width);
   assign row_end      = out_row_next >= CmpBits'(live_height);
   assign last         = col_end && row_end;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      armed_in   = armed_ff;
      fire_in    = fire_ff;
      if (cmd.accept) begin
         fire_in = armed_ff || (in_row_ff >= RowBits'(2)) ||
                   ((in_row_ff == RowBits'(1)) && (in_col_ff != '0));
         armed_in = armed_ff || fire_in;
         if (in_col_end) begin
            in_col_in = '0;
            if (in_row_ff != RowMax) in_row_in = in_row_ff + RowBits'(1);
         end else begin
            in_col_in = in_col_ff + ColBits'(1);
         end
      end
      if (cmd.emit) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            armed_in   = 1'b0;
         end else if (col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + RowBits'(1);
         end else begin
            out_col_in = out_col_ff + ColBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         armed_ff   <= 1'b0;
         fire_ff    <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         armed_ff   <= armed_in;
         fire_ff    <= fire_in;
      end
   end

   // ---- line buffers: read on accept, write back on shift ----
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         top_rd_ff <= upper_mem[in_col_ff];
         mid_rd_ff <= middle_mem[in_col_ff];
         addr_ff   <= in_col_ff;
         px_ff     <= req_data.drain ? '0 :
                      {req_data.alpha_in, req_data.blue_in,
                       req_data.green_in, req_data.red_in};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         upper_mem[addr_ff]  <= mid_rd_ff;
         middle_mem[addr_ff] <= px_ff;
      end
   end

   // ---- 3x3 window, newest column on the right ----
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= top_rd_ff;
         win_ff[5] <= mid_rd_ff;
         win_ff[8] <= px_ff;
      end
   end

   // ---- masked sums ----
   assign row_ok = {!row_end, 1'b1, (out_row_ff != '0)};
   assign col_ok = {!col_end, 1'b1, (out_col_ff != '0)};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            use_mask[r*3+c] = row_ok[r] && col_ok[c];
         end
      end
      cnt_in = CntBits'($countones(use_mask));
      for (int ch = 0; ch < 4; ch++) begin
         sum_in[ch] = '0;
         for (int i = 0; i < 9; i++) begin
            if (use_mask[i]) begin
               sum_in[ch] = sum_in[ch] +
                            SumBits'(win_ff[i][ch*ChanBits +: ChanBits]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         for (int ch = 0; ch < 4; ch++) sum_ff[ch] <= sum_in[ch];
         cnt_ff <= cnt_in;
      end
   end

   // ---- divide by 1..9 as multiply by reciprocal ----
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         for (int ch = 0; ch < 4; ch++) begin
            prod_ff[ch] <= ProdBits'(sum_ff[ch]) * ProdBits'(recip(cnt_ff));
         end
      end
   end

   // ---- result register ----
   always_comb begin
      rsp_data_in.red_out    = prod_ff[0][RecipShift +: ChanBits];
      rsp_data_in.green_out  = prod_ff[1][RecipShift +: ChanBits];
      rsp_data_in.blue_out   = prod_ff[2][RecipShift +: ChanBits];
      rsp_data_in.alpha_out  = prod_ff[3][RecipShift +: ChanBits];
      rsp_data_in.frame_last = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.fire     = fire_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

>>> hw/rtl/box_blur_3x3_rgba.sv
// 3x3 box blur over an RGBA raster stream. Each req beat carries one pixel
// (or a drain beat); each rsp beat is the truncated per-channel mean of the
// in-image 3x3 neighbourhood of a pixel (4 at corners, 6 on edges, 9
// inside), with frame_last on the final pixel of the frame. Results lag
// inputs by image_width+1 beats, so after a frame the source sends
// image_width+1 drain beats. One beat is handled at a time: a beat that
// yields no result goes through line-buffer read, then write-back and
// window shift; a beat that yields a result goes through read, shift, sum,
// reciprocal multiply and result load, waiting to load while the rsp
// register is full. The registered read of the single-port line buffers
// and the sum/multiply steps set this sequence. The rsp register lets the
// next req beat in while a result still waits. Line buffers are not
// cleared after reset; they need no clearing pass since only written entries
// reach an in-image result. Write image_width/image_height only while idle.
// Depends on bbr_pkg, bbr_ctrl and bbr_dpath.
module box_blur_3x3_rgba import bbr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pixel_in_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pixel_out_type       rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IdxBits-1:0]  csr_index,
   input  logic [CfgBits-1:0]  csr_wdata
);

   logic [CfgBits-1:0] width_ff, width_in, height_ff, height_in;
   logic [CfgBits-1:0] live_width, live_height;
   dp_cmd_type         cmd;
   dp_status_type      status;

   // config registers: always ready, unknown indexes ignored
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero acts as one; width clamps to the line buffer depth
   always_comb begin
      if (width_ff == '0) begin
         live_width = CfgBits'(1);
      end else if (width_ff > CfgBits'(MaxWidth)) begin
         live_width = CfgBits'(MaxWidth);
      end else begin
         live_width = width_ff;
      end
      live_height = (height_ff == '0) ? CfgBits'(1) : height_ff;
   end

   bbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bbr_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .live_width  (live_width),
      .live_height (live_height),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // an accepted beat always goes on to the write-back step
   a_accept_then_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.shift && !req_ready)
      else $error("accepted beat not followed by line-buffer write-back");

   // a new result appears only from a load command
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("rsp valid rose without a result load");

   // never load a result over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !cmd.emit)
      else $error("result register overwritten while stalled");

   // only one step of the sequencer is active at a time
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.shift, cmd.sum, cmd.mul, cmd.emit}))
      else $error("more than one datapath command at once");

endmodule
